// ===== sv/skh_pkg.sv =====
// ----------------------------------------------------------------------------
// skh_pkg
// shared types, constants and round functions of the siphash-1-3 unit
// ----------------------------------------------------------------------------
package skh_pkg;

   localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
   localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
   localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
   localparam logic [63:0] SIP_C3 = 64'h7465646279746573;

   localparam logic [63:0] KEY_LOW_RESET  = 64'h0706050403020100;
   localparam logic [63:0] KEY_HIGH_RESET = 64'h0f0e0d0c0b0a0908;
   localparam logic [63:0] FINAL_XOR      = 64'h00000000000000ff;

   localparam logic [3:0]  FULL_WORD_BYTES = 4'd8;
   localparam int          BACK_STAGES     = 4;   // tail round plus three final rounds

   // configuration register indexes
   localparam logic CSR_KEY_LOW  = 1'b0;
   localparam logic CSR_KEY_HIGH = 1'b1;

   typedef struct packed {
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] c;
      logic [63:0] d;
   } lanes_type;

   // one finished message waiting for finalization
   typedef struct packed {
      lanes_type   lanes;
      logic [63:0] tail;
      logic        empty;
   } entry_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

   function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned n);
      rotl = (x << n) | (x >> (64 - n));
   endfunction

   function automatic lanes_type sip_round(input lanes_type v);
      lanes_type r;
      r = v;
      r.a = r.a + r.b; r.b = rotl(r.b, 13); r.b = r.b ^ r.a; r.a = rotl(r.a, 32);
      r.c = r.c + r.d; r.d = rotl(r.d, 16); r.d = r.d ^ r.c;
      r.a = r.a + r.d; r.d = rotl(r.d, 21); r.d = r.d ^ r.a;
      r.c = r.c + r.b; r.b = rotl(r.b, 17); r.b = r.b ^ r.c; r.c = rotl(r.c, 32);
      return r;
   endfunction

   function automatic lanes_type sip_compress(input lanes_type v, input logic [63:0] m);
      lanes_type r;
      r   = v;
      r.d = r.d ^ m;
      r   = sip_round(r);
      r.a = r.a ^ m;
      return r;
   endfunction

   function automatic lanes_type init_lanes(input logic [63:0] k0, input logic [63:0] k1);
      lanes_type r;
      r.a = k0 ^ SIP_C0;
      r.b = k1 ^ SIP_C1;
      r.c = k0 ^ SIP_C2;
      r.d = k1 ^ SIP_C3;
      return r;
   endfunction

   // keeps the low count bytes of a word
   function automatic logic [63:0] byte_mask(input logic [3:0] count);
      logic [63:0] m;
      m = '0;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < count) begin
            m[i*8 +: 8] = 8'hff;
         end
      end
      return m;
   endfunction

endpackage

// ===== sv/skh_if.sv =====
// ----------------------------------------------------------------------------
// skh channel interfaces
// valid/ready channels for message words and hash results
// ----------------------------------------------------------------------------
interface skh_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] message_word;
   logic [3:0]  byte_count;
   logic        last_word;

   modport source (output valid, message_word, byte_count, last_word, input ready);
   modport sink   (input valid, message_word, byte_count, last_word, output ready);
endinterface

interface skh_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] hash_value;

   modport source (output valid, hash_value, input ready);
   modport sink   (input valid, hash_value, output ready);
endinterface

// ===== sv/skh_front.sv =====
// ----------------------------------------------------------------------------
// skh_front
// accepts message words, compresses full words, hands finished messages on
// ----------------------------------------------------------------------------
module skh_front (
   input  logic                     clock,
   input  logic                     reset,
   skh_req_if.sink                  req_chan,
   input  logic [63:0]              key_low,
   input  logic [63:0]              key_high,
   input  skh_pkg::queue_status_type q_status,
   output logic                     push,
   output skh_pkg::entry_type       push_entry
);
   import skh_pkg::*;

   lanes_type   lanes_ff, lanes_in;
   logic [7:0]  len_ff, len_in;
   logic        open_ff, open_in;

   logic        accept;
   logic        first;
   logic [3:0]  count;
   lanes_type   base;
   lanes_type   comp;
   logic [7:0]  base_len;
   logic [7:0]  tail_len;
   logic [63:0] tail;

   assign req_chan.ready = !q_status.full;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      first    = !open_ff;
      count    = (req_chan.byte_count > FULL_WORD_BYTES) ? FULL_WORD_BYTES
                                                          : req_chan.byte_count;
      base     = first ? init_lanes(key_low, key_high) : lanes_ff;
      base_len = first ? 8'd0 : len_ff;
      comp     = sip_compress(base, req_chan.message_word);
      tail_len = base_len + 8'(count);
      tail     = (count == FULL_WORD_BYTES) ? 64'd0
                                            : (req_chan.message_word & byte_mask(count));
      tail[63:56] = tail_len;

      push             = accept && req_chan.last_word;
      push_entry.lanes = (count == FULL_WORD_BYTES) ? comp : base;
      push_entry.tail  = tail;
      push_entry.empty = first && (count == 4'd0);

      lanes_in = lanes_ff;
      len_in   = len_ff;
      open_in  = open_ff;
      if (accept) begin
         if (req_chan.last_word) begin
            open_in = 1'b0;
         end else begin
            lanes_in = comp;
            len_in   = base_len + 8'd8;
            open_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      lanes_ff <= lanes_in;
      len_ff   <= len_in;
      if (reset) begin
         open_ff <= 1'b0;
      end else begin
         open_ff <= open_in;
      end
   end

endmodule

// ===== sv/skh_queue.sv =====
// ----------------------------------------------------------------------------
// skh_queue
// short fifo of finished messages between front and back
// ----------------------------------------------------------------------------
module skh_queue #(
   parameter int DEPTH = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  skh_pkg::entry_type        push_entry,
   input  logic                      pop,
   output skh_pkg::entry_type        head,
   output skh_pkg::queue_status_type status
);
   import skh_pkg::*;

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   entry_type            slots_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0]   count_ff, count_in;

   assign head             = slots_ff[rd_ptr_ff];
   assign status.not_empty = (count_ff != '0);
   assign status.full      = (count_ff == COUNT_W'(DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      status.full |-> !push)
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> status.not_empty)
      else $error("queue read while empty");

endmodule

// ===== sv/skh_back.sv =====
// ----------------------------------------------------------------------------
// skh_back
// finalization pipeline: tail round, three final rounds, result register
// ----------------------------------------------------------------------------
module skh_back (
   input  logic                      clock,
   input  logic                      reset,
   input  skh_pkg::entry_type        head,
   input  skh_pkg::queue_status_type q_status,
   output logic                      pop,
   skh_rsp_if.source                 rsp_chan
);
   import skh_pkg::*;

   logic        st_valid_ff [BACK_STAGES];
   logic        st_empty_ff [BACK_STAGES];
   lanes_type   st_lanes_ff [BACK_STAGES];
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_hash_ff, rsp_hash_in;

   logic        advance;
   lanes_type   tail_lanes;
   lanes_type   last_lanes;

   assign advance = !rsp_valid_ff || rsp_chan.ready;
   assign pop     = advance && q_status.not_empty;

   always_comb begin
      tail_lanes   = sip_compress(head.lanes, head.tail);
      tail_lanes.c = tail_lanes.c ^ FINAL_XOR;
      last_lanes   = st_lanes_ff[BACK_STAGES-1];
      rsp_hash_in  = st_empty_ff[BACK_STAGES-1] ? 64'd0
                   : (last_lanes.a ^ last_lanes.b ^ last_lanes.c ^ last_lanes.d);
      rsp_valid_in = st_valid_ff[BACK_STAGES-1];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st_lanes_ff[0] <= tail_lanes;
         st_empty_ff[0] <= head.empty;
         for (int i = 1; i < BACK_STAGES; i++) begin
            st_lanes_ff[i] <= sip_round(st_lanes_ff[i-1]);
            st_empty_ff[i] <= st_empty_ff[i-1];
         end
         rsp_hash_ff <= rsp_hash_in;
      end
      if (reset) begin
         for (int i = 0; i < BACK_STAGES; i++) begin
            st_valid_ff[i] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         st_valid_ff[0] <= q_status.not_empty;
         for (int i = 1; i < BACK_STAGES; i++) begin
            st_valid_ff[i] <= st_valid_ff[i-1];
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.hash_value = rsp_hash_ff;

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(st_valid_ff[BACK_STAGES-1]) && $stable(rsp_hash_ff)))
      else $error("pipeline moved while result stalled");
   a_empty_is_zero: assert property (@(posedge clock) disable iff (reset)
      (advance && st_valid_ff[BACK_STAGES-1] && st_empty_ff[BACK_STAGES-1])
      |=> (rsp_valid_ff && rsp_hash_ff == 64'd0))
      else $error("empty message gave nonzero hash");

endmodule

// ===== sv/keyed_siphash_1_3_unit.sv =====
// ----------------------------------------------------------------------------
// keyed_siphash_1_3_unit
// keyed siphash-1-3 over 64-bit little-endian message words
// ----------------------------------------------------------------------------
// usage
//   req_chan carries one message word per transaction: message_word (first
//   byte in bits 7:0), byte_count (0..8, taken as 8 above eight and for any
//   word that is not last) and last_word. rsp_chan carries one hash_value
//   per message, in message order; an empty message gives 0.
//   csr_* writes key_low (index 0) or key_high (index 1); a new key applies
//   from the next message start.
// throughput and pipeline
//   one word per cycle while the queue is not full: the front runs one
//   compression round per word combinationally, the back runs tail and
//   final rounds as a four-stage pipeline, so messages may follow back
//   to back. after the last word is accepted, the hash passes the queue,
//   the four round stages and then the result register when nothing stalls.
// reset
//   synchronous; clears the queue, pipeline and message state, keys return
//   to 0x0706050403020100 / 0x0f0e0d0c0b0a0908.
// stall
//   a held result freezes the back pipeline; finished messages collect in
//   the queue, and req_chan.ready drops only when the queue is full.
// ----------------------------------------------------------------------------
module keyed_siphash_1_3_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   skh_req_if.sink     req_chan,
   skh_rsp_if.source   rsp_chan,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [63:0] csr_write_data
);
   import skh_pkg::*;

   logic [63:0]      key_low_ff;
   logic [63:0]      key_high_ff;

   queue_status_type q_status;
   logic             push;
   entry_type        push_entry;
   logic             pop;
   entry_type        head;

   // key registers; the user must write them only while idle, the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= KEY_LOW_RESET;
         key_high_ff <= KEY_HIGH_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_KEY_LOW:  key_low_ff  <= csr_write_data;
            CSR_KEY_HIGH: key_high_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // front: lane state per message, one compression per accepted word
   skh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .key_low    (key_low_ff),
      .key_high   (key_high_ff),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   // finished messages wait here for the finalization pipeline
   skh_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   // back: tail round, three final rounds, result register
   skh_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

   // a last word is only taken with room in the queue
   a_accept_room: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.last_word) |-> !q_status.full)
      else $error("last word accepted with full queue");

endmodule
